// File: rtl/oneshot_timer_slot_table_top_macros.svh
// Assertion macros for the one-shot timer slot table.
`ifndef ONESHOT_TIMER_SLOT_TABLE_TOP_MACROS_SVH
`define ONESHOT_TIMER_SLOT_TABLE_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define OTST_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);
// prop must never hold outside reset
`define OTST_NEVER(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(prop)) else $error(msg);
`else
`define OTST_ASSERT(lbl, ck, rn, prop, msg)
`define OTST_NEVER(lbl, ck, rn, prop, msg)
`endif

`endif

// File: rtl/otst_pkg.sv
// Package: sizes, codes and types of the one-shot timer slot table.
package otst_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int TAG_BITS  = 16;

    localparam int IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int TAG_W  = (TAG_BITS < 16) ? TAG_BITS : 16;
    localparam int TIME_W = 32;
    localparam int RAM_W  = TIME_W + TAG_W;

    typedef enum logic [2:0] {
        CMD_SCHEDULE   = 3'd0,
        CMD_CANCEL     = 3'd1,
        CMD_CANCEL_ALL = 3'd2,
        CMD_TICK       = 3'd3,
        CMD_QUERY      = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_ACK    = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_FIRED  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_CLOSE
    } state_t;

endpackage

// File: rtl/otst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module otst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/otst_due.sv
// Shared due check: an armed slot is due when now has reached its fire time.
module otst_due (
    input  logic [otst_pkg::TIME_W-1:0] now_ms,
    input  logic [otst_pkg::TIME_W-1:0] fire_ms,
    input  logic                        armed,
    output logic                        due
);

    // plain unsigned compare, no wrap handling
    assign due = armed && (now_ms >= fire_ms);

endmodule

// File: rtl/oneshot_timer_slot_table_top.sv
// Top level: command decode, slot scan sequencer and result register.
//
// A command is taken when start is high and busy is low. Schedule, cancel,
// cancel-all, query and unknown codes leave busy low and give one result,
// marked last, on the cycle after acceptance; such commands can be issued
// every cycle. A tick holds busy high for the whole scan: the sequencer
// reads one slot a cycle through the read port of the slot RAM
// and runs it through one due comparator, so the scan length is set by the
// slot count. Fired results come out one a cycle while the scan runs, and a
// closing result marked last follows; busy is low again in that cycle.
// Every result is valid for one cycle only; the receiver must take it then.
`include "oneshot_timer_slot_table_top_macros.svh"

module oneshot_timer_slot_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [31:0] now_ms,
    input  logic [31:0] delay_ms,
    input  logic        has_action,
    input  logic [15:0] user_tag,
    input  logic [7:0]  slot_index,
    output logic        result_valid,
    output logic [1:0]  kind,
    output logic [3:0]  slot_out,
    output logic [15:0] tag_out,
    output logic        is_active,
    output logic [4:0]  pending_count,
    output logic        last
);

    otst_pkg::state_t state_reg, state_next;

    logic [otst_pkg::NUM_SLOTS-1:0] busy_reg, busy_next;
    logic [otst_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [otst_pkg::IDX_W-1:0]     scan_reg, scan_next;
    logic [otst_pkg::IDX_W-1:0]     chk_idx_reg, chk_idx_next;
    logic                           chk_valid_reg, chk_valid_next;
    logic [otst_pkg::TIME_W-1:0]    now_reg, now_next;

    logic                vld_reg, vld_next;
    otst_pkg::kind_t     kind_reg, kind_next;
    logic [3:0]          slot_reg, slot_next;
    logic [15:0]         tag_reg, tag_next;
    logic                act_reg, act_next;
    logic [4:0]          pcnt_reg, pcnt_next;
    logic                last_reg, last_next;

    logic                        ram_we;
    logic [otst_pkg::RAM_W-1:0]  ram_wdata;
    logic [otst_pkg::RAM_W-1:0]  ram_rdata;

    logic                        free_found;
    logic [otst_pkg::IDX_W-1:0]  free_idx;
    logic                        idx_ok;
    logic [otst_pkg::IDX_W-1:0]  idx_sel;
    logic                        due;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = otst_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = otst_pkg::IDX_W'(i);
            end
        end
    end

    assign idx_ok    = slot_index < 8'(otst_pkg::NUM_SLOTS);
    assign idx_sel   = slot_index[otst_pkg::IDX_W-1:0];
    assign ram_wdata = {user_tag[otst_pkg::TAG_W-1:0], now_ms + delay_ms};

    otst_ram #(
        .WIDTH (otst_pkg::RAM_W),
        .DEPTH (otst_pkg::NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    otst_due u_due (
        .now_ms  (now_reg),
        .fire_ms (ram_rdata[otst_pkg::TIME_W-1:0]),
        .armed   (chk_valid_reg && busy_reg[chk_idx_reg]),
        .due     (due)
    );

    always_comb
    begin
        state_next     = state_reg;
        busy_next      = busy_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = 1'b0;
        now_next       = now_reg;
        ram_we         = 1'b0;

        vld_next  = 1'b0;
        kind_next = kind_reg;
        slot_next = slot_reg;
        tag_next  = tag_reg;
        act_next  = act_reg;
        pcnt_next = pcnt_reg;
        last_next = last_reg;

        case (state_reg)
            otst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    vld_next  = 1'b1;
                    kind_next = otst_pkg::KIND_ACK;
                    slot_next = '0;
                    tag_next  = '0;
                    act_next  = 1'b0;
                    last_next = 1'b1;
                    case (otst_pkg::cmd_t'(command))
                        otst_pkg::CMD_SCHEDULE:
                        begin
                            if (has_action && free_found)
                            begin
                                ram_we              = 1'b1;
                                busy_next[free_idx] = 1'b1;
                                count_next          = count_reg + 1'b1;
                                slot_next           = 4'(free_idx);
                            end
                            else
                            begin
                                kind_next = otst_pkg::KIND_REJECT;
                            end
                        end
                        otst_pkg::CMD_CANCEL:
                        begin
                            if (idx_ok && busy_reg[idx_sel])
                            begin
                                busy_next[idx_sel] = 1'b0;
                                count_next         = count_reg - 1'b1;
                            end
                        end
                        otst_pkg::CMD_CANCEL_ALL:
                        begin
                            busy_next  = '0;
                            count_next = '0;
                        end
                        otst_pkg::CMD_TICK:
                        begin
                            vld_next   = 1'b0;
                            now_next   = now_ms;
                            scan_next  = '0;
                            state_next = otst_pkg::ST_SCAN;
                        end
                        otst_pkg::CMD_QUERY:
                        begin
                            act_next = idx_ok && busy_reg[idx_sel];
                        end
                        default:
                        begin
                            kind_next = otst_pkg::KIND_REJECT;
                        end
                    endcase
                end
            end
            otst_pkg::ST_SCAN, otst_pkg::ST_TAIL:
            begin
                // issue the read for scan_reg, check the slot read last cycle
                if (state_reg == otst_pkg::ST_SCAN)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = scan_reg;
                    scan_next      = otst_pkg::IDX_W'(scan_reg + 1'b1);
                    if (scan_reg == otst_pkg::IDX_W'(otst_pkg::NUM_SLOTS - 1))
                    begin
                        state_next = otst_pkg::ST_TAIL;
                    end
                end
                else
                begin
                    state_next = otst_pkg::ST_CLOSE;
                end
                if (due)
                begin
                    busy_next[chk_idx_reg] = 1'b0;
                    count_next             = count_reg - 1'b1;
                    vld_next               = 1'b1;
                    kind_next              = otst_pkg::KIND_FIRED;
                    slot_next              = 4'(chk_idx_reg);
                    tag_next               = 16'(ram_rdata[otst_pkg::RAM_W-1:otst_pkg::TIME_W]);
                    act_next               = 1'b0;
                    last_next              = 1'b0;
                end
            end
            otst_pkg::ST_CLOSE:
            begin
                vld_next   = 1'b1;
                kind_next  = otst_pkg::KIND_ACK;
                slot_next  = '0;
                tag_next   = '0;
                act_next   = 1'b0;
                last_next  = 1'b1;
                state_next = otst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = otst_pkg::ST_IDLE;
            end
        endcase

        if (vld_next)
        begin
            pcnt_next = 5'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= otst_pkg::ST_IDLE;
            busy_reg      <= '0;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            vld_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            vld_reg       <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg    <= scan_next;
        chk_idx_reg <= chk_idx_next;
        now_reg     <= now_next;
        kind_reg    <= kind_next;
        slot_reg    <= slot_next;
        tag_reg     <= tag_next;
        act_reg     <= act_next;
        pcnt_reg    <= pcnt_next;
        last_reg    <= last_next;
    end

    assign busy          = (state_reg != otst_pkg::ST_IDLE);
    assign result_valid  = vld_reg;
    assign kind          = kind_reg;
    assign slot_out      = slot_reg;
    assign tag_out       = tag_reg;
    assign is_active     = act_reg;
    assign pending_count = pcnt_reg;
    assign last          = last_reg;

    `OTST_ASSERT(a_count_matches, clk, rst_n, $countones(busy_reg) == int'(count_reg), "pending count out of step with busy slots")
    `OTST_NEVER(a_last_while_busy, clk, rst_n, result_valid && last && busy, "closing result while sequencer still busy")
    `OTST_ASSERT(a_fired_inside_tick, clk, rst_n, (result_valid && !last) |-> (busy && kind == otst_pkg::KIND_FIRED), "non-closing result outside a tick scan")
    `OTST_ASSERT(a_short_cmd_answers, clk, rst_n, (start && !busy && command != otst_pkg::CMD_TICK) |=> (result_valid && last), "short command gave no single result")
    `OTST_ASSERT(a_tick_enters_scan, clk, rst_n, (start && !busy && command == otst_pkg::CMD_TICK) |=> (busy && !result_valid), "tick did not start a scan")

endmodule
